// ===== design/des_rf_pkg.sv =====
// ----------------------------------------------------------------------------
// des_rf_pkg
// Widths, permutation and S-box tables and helper functions for the DES
// round function pipeline. Bit 1 is the MSB of a word, as in the standard.
// ----------------------------------------------------------------------------
package des_rf_pkg;

	localparam int HALF_W = 32;
	localparam int KEY_W  = 48;
	localparam int SBOX_N = 8;

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [KEY_W-1:0]  key_t;

	localparam logic [5:0] E_TABLE [0:47] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	localparam logic [5:0] P_TABLE [0:31] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	// entry [box][row * 16 + column]
	localparam logic [3:0] S_TABLE [0:7][0:63] = '{
		'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		  4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
		  4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
		  4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
		  4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
		  4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
		  4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
		  4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
		'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
		  4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
		  4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
		  4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
		  4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
		  4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
		  4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
		  4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
		'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
		  4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
		  4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
		  4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
		  4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
		  4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
		  4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
		  4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
		'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
		  4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
		  4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
		  4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
		  4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
		  4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
		  4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
		  4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
		'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
		  4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
		  4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
		  4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
		  4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
		  4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
		  4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
		  4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
		'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
		  4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
		  4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
		  4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
		  4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
		  4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
		  4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
		  4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
		'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
		  4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
		  4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
		  4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
		  4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
		  4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
		  4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
		  4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
		'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
		  4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
		  4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
		  4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
		  4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
		  4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
		  4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
		  4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
	};

	// bit n of a 32-bit word, n = 1 is the MSB
	function automatic logic pick_bit(input half_t word, input logic [5:0] n);
		logic [4:0] pos;
		pos = 5'(6'd32 - n);
		return word[pos];
	endfunction

	function automatic key_t e_expand(input half_t word);
		key_t r;
		for (int i = 0; i < KEY_W; i++) begin
			r[KEY_W-1-i] = pick_bit(word, E_TABLE[i]);
		end
		return r;
	endfunction

	function automatic half_t p_permute(input half_t word);
		half_t r;
		for (int i = 0; i < HALF_W; i++) begin
			r[HALF_W-1-i] = pick_bit(word, P_TABLE[i]);
		end
		return r;
	endfunction

	// eight 6-to-4 lookups, outer bits select row, inner bits column
	function automatic half_t sbox_all(input key_t x);
		half_t r;
		logic [5:0] grp;
		for (int i = 0; i < SBOX_N; i++) begin
			grp = x[KEY_W-1-6*i -: 6];
			r[HALF_W-1-4*i -: 4] = S_TABLE[i][{grp[5], grp[0], grp[4:1]}];
		end
		return r;
	endfunction

endpackage

// ===== design/des_rf_expand.sv =====
// ----------------------------------------------------------------------------
// des_rf_expand
// First stage: E expansion of the half block and XOR with the round key.
// ----------------------------------------------------------------------------
module des_rf_expand (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  des_rf_pkg::half_t half_block,
	input  des_rf_pkg::key_t  round_key,
	output logic              out_valid,
	input  logic              out_stall,
	output des_rf_pkg::key_t  mixed
);
	import des_rf_pkg::*;

	logic valid_s1;
	key_t mixed_s1;

	// hold while the next stage refuses a full register
	assign in_stall  = valid_s1 & out_stall;
	assign out_valid = valid_s1;
	assign mixed     = mixed_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mixed_s1 <= e_expand(half_block) ^ round_key;
		end
	end

endmodule

// ===== design/des_rf_sbox.sv =====
// ----------------------------------------------------------------------------
// des_rf_sbox
// Second stage: eight parallel S-box lookups on the mixed 48-bit word.
// ----------------------------------------------------------------------------
module des_rf_sbox (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  des_rf_pkg::key_t  mixed,
	output logic              out_valid,
	input  logic              out_stall,
	output des_rf_pkg::half_t subst
);
	import des_rf_pkg::*;

	logic  valid_s2;
	half_t subst_s2;

	assign in_stall  = valid_s2 & out_stall;
	assign out_valid = valid_s2;
	assign subst     = subst_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!in_stall) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			subst_s2 <= sbox_all(mixed);
		end
	end

endmodule

// ===== design/des_rf_perm.sv =====
// ----------------------------------------------------------------------------
// des_rf_perm
// Third stage: P permutation into the output register.
// ----------------------------------------------------------------------------
module des_rf_perm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  des_rf_pkg::half_t subst,
	output logic              out_valid,
	input  logic              out_stall,
	output des_rf_pkg::half_t f_result
);
	import des_rf_pkg::*;

	logic  valid_s3;
	half_t result_s3;

	assign in_stall  = valid_s3 & out_stall;
	assign out_valid = valid_s3;
	assign f_result  = result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!in_stall) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			result_s3 <= p_permute(subst);
		end
	end

endmodule

// ===== design/des_round_function.sv =====
// ----------------------------------------------------------------------------
// des_round_function
// DES Feistel round function f: E expansion, key XOR, S-boxes, P permutation.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns f(half_block,
// round_key) through three register stages (expand and key XOR,
// S-box lookup, P permutation into the output register). Each stage holds
// its word only while the stage after it is full and stalled, so empty
// stages fill even while the output stalls; throughput is one word per
// cycle whenever out_stall is low. Bit 1 of each field is its MSB.
module des_round_function (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  des_rf_pkg::half_t half_block,
	input  des_rf_pkg::key_t  round_key,
	output logic              out_valid,
	input  logic              out_stall,
	output des_rf_pkg::half_t f_result
);
	import des_rf_pkg::*;

	logic  valid_a, stall_a;
	logic  valid_b, stall_b;
	key_t  mixed;
	half_t subst;

	des_rf_expand u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.half_block (half_block),
		.round_key  (round_key),
		.out_valid  (valid_a),
		.out_stall  (stall_a),
		.mixed      (mixed)
	);

	des_rf_sbox u_sbox (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_a),
		.in_stall  (stall_a),
		.mixed     (mixed),
		.out_valid (valid_b),
		.out_stall (stall_b),
		.subst     (subst)
	);

	des_rf_perm u_perm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_b),
		.in_stall  (stall_b),
		.subst     (subst),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.f_result  (f_result)
	);

endmodule
